@@ src/slt_pkg.sv @@
// shared constants and types for the sector cache tag and replacement controller
// no dependencies
`default_nettype none

package slt_pkg;

   // cache geometry
   localparam int CACHE_WAYS  = 8;
   localparam int WAY_W       = 3;
   localparam int NUM_SECTORS = 1024;
   localparam int SECTOR_W    = 10;
   localparam int STAMP_W     = 32;

   // first level of the oldest-stamp tree pairs neighboring ways
   localparam int PAIR_N = CACHE_WAYS / 2;
   localparam int PAIR_W = WAY_W - 1;

   // request opcodes
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;  // latch the request and the first tree level
      logic exec;     // finish the search, update the ways, load the result
   } slt_cmd_type;

endpackage : slt_pkg

`default_nettype wire

@@ src/slt_ctrl.sv @@
// controller state machine for the sector cache tag controller
// depends on slt_pkg
`default_nettype none

module slt_ctrl
   import slt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   output slt_cmd_type      cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   // next state: each accepted request moves to the execute state, then back to idle
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands to the datapath
   assign busy        = (state_ff == ST_EXEC);
   assign cmd.capture = (state_ff == ST_IDLE) && start;
   assign cmd.exec    = (state_ff == ST_EXEC);

endmodule : slt_ctrl

`default_nettype wire

@@ src/slt_dp.sv @@
// datapath: way tags, valid bits, stamps, hit and victim search, result registers
// depends on slt_pkg
`default_nettype none

module slt_dp
   import slt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire slt_cmd_type         cmd,
   input  wire logic                req_opcode,
   input  wire logic [SECTOR_W-1:0] req_sector,
   input  wire logic [STAMP_W-1:0]  req_now_tick,
   output logic                     rsp_valid,
   output logic                     rsp_hit,
   output logic [WAY_W-1:0]         rsp_way,
   output logic                     rsp_filled,
   output logic                     rsp_evicted_valid,
   output logic                     rsp_invalidated
);

   // way state
   logic [CACHE_WAYS-1:0]             valid_ff;
   logic [CACHE_WAYS-1:0]             valid_in;
   logic [CACHE_WAYS-1:0][SECTOR_W-1:0] sector_ff;
   logic [CACHE_WAYS-1:0][STAMP_W-1:0]  stamp_ff;

   // captured request
   logic                 op_ff;
   logic [SECTOR_W-1:0]  sec_ff;
   logic [STAMP_W-1:0]   tick_ff;
   logic [CACHE_WAYS-1:0] match_ff;
   logic [CACHE_WAYS-1:0] match_in;

   // first tree level: winner of each pair and its stamp
   logic [PAIR_N-1:0]              pair_sel_ff;
   logic [PAIR_N-1:0]              pair_sel_in;
   logic [PAIR_N-1:0][STAMP_W-1:0] pair_stamp_ff;
   logic [PAIR_N-1:0][STAMP_W-1:0] pair_stamp_in;

   // result registers
   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic [WAY_W-1:0]  rsp_way_ff;
   logic              rsp_filled_ff;
   logic              rsp_evicted_ff;
   logic              rsp_inval_ff;

   // execute-cycle decisions
   logic              hit_any;
   logic [WAY_W-1:0]  hit_idx;
   logic              inv_any;
   logic [WAY_W-1:0]  inv_idx;
   logic [PAIR_W-1:0] old_pair;
   logic [STAMP_W-1:0] old_stamp;
   logic [WAY_W-1:0]  old_idx;
   logic [WAY_W-1:0]  victim_idx;
   logic              do_fill;
   logic              do_touch;

   // tag compare against the incoming sector, qualified by valid
   always_comb begin
      for (int i = 0; i < CACHE_WAYS; i++) begin
         match_in[i] = valid_ff[i] && (sector_ff[i] == req_sector);
      end
   end

   // first level of the oldest-stamp tree, lower way wins a tie
   always_comb begin
      for (int p = 0; p < PAIR_N; p++) begin
         pair_sel_in[p]   = stamp_ff[2*p+1] < stamp_ff[2*p];
         pair_stamp_in[p] = pair_sel_in[p] ? stamp_ff[2*p+1] : stamp_ff[2*p];
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff         <= req_opcode;
         sec_ff        <= req_sector;
         tick_ff       <= req_now_tick;
         match_ff      <= match_in;
         pair_sel_ff   <= pair_sel_in;
         pair_stamp_ff <= pair_stamp_in;
      end
   end

   // lowest matching way and lowest invalid way
   always_comb begin
      hit_idx = '0;
      inv_idx = '0;
      for (int i = CACHE_WAYS - 1; i >= 0; i--) begin
         if (match_ff[i]) hit_idx = WAY_W'(i);
         if (!valid_ff[i]) inv_idx = WAY_W'(i);
      end
      hit_any = |match_ff;
      inv_any = ~&valid_ff;
   end

   // remaining tree levels as a scan over the pair winners
   always_comb begin
      old_pair  = '0;
      old_stamp = pair_stamp_ff[0];
      for (int p = 1; p < PAIR_N; p++) begin
         if (pair_stamp_ff[p] < old_stamp) begin
            old_stamp = pair_stamp_ff[p];
            old_pair  = PAIR_W'(p);
         end
      end
      old_idx = {old_pair, pair_sel_ff[old_pair]};
   end

   // victim choice and update enables
   assign victim_idx = inv_any ? inv_idx : old_idx;
   assign do_touch   = cmd.exec && (op_ff == OP_READ) && hit_any;
   assign do_fill    = cmd.exec && (op_ff == OP_READ) && !hit_any;

   // valid bits: writes clear matching ways, fills set the victim
   always_comb begin
      valid_in = valid_ff;
      if (cmd.exec && (op_ff == OP_WRITE)) begin
         valid_in = valid_ff & ~match_ff;
      end else if (do_fill) begin
         valid_in[victim_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // tag and stamp update
   always_ff @(posedge clock) begin
      if (do_touch) begin
         stamp_ff[hit_idx] <= tick_ff;
      end else if (do_fill) begin
         stamp_ff[victim_idx]  <= tick_ff;
         sector_ff[victim_idx] <= sec_ff;
      end
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.exec;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_hit_ff     <= do_touch;
         rsp_filled_ff  <= do_fill;
         rsp_evicted_ff <= do_fill && !inv_any;
         rsp_inval_ff   <= (op_ff == OP_WRITE) && hit_any;
         if (op_ff == OP_WRITE) begin
            rsp_way_ff <= '0;
         end else if (hit_any) begin
            rsp_way_ff <= hit_idx;
         end else begin
            rsp_way_ff <= victim_idx;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_way           = rsp_way_ff;
   assign rsp_filled        = rsp_filled_ff;
   assign rsp_evicted_valid = rsp_evicted_ff;
   assign rsp_invalidated   = rsp_inval_ff;

endmodule : slt_dp

`default_nettype wire

@@ src/sector_cache_lru_tags.sv @@
// sector cache tag controller, top level: controller plus datapath
// depends on slt_pkg, slt_ctrl, slt_dp
// a request is taken only while busy is low. the accept cycle compares tags
// and runs the first level of the oldest-stamp tree, the execute cycle
// finishes the search and updates the ways. rsp_valid pulses in the cycle
// after the execute cycle. the receiver cannot stall. synchronous reset
// clears all valid bits and the controller.
`default_nettype none

module sector_cache_lru_tags
   import slt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_opcode,
   input  wire logic [SECTOR_W-1:0] req_sector,
   input  wire logic [STAMP_W-1:0]  req_now_tick,
   output logic                     rsp_valid,
   output logic                     rsp_hit,
   output logic [WAY_W-1:0]         rsp_way,
   output logic                     rsp_filled,
   output logic                     rsp_evicted_valid,
   output logic                     rsp_invalidated
);

   slt_cmd_type cmd;

   // sequencing
   slt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // tags, stamps and result
   slt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_opcode        (req_opcode),
      .req_sector        (req_sector),
      .req_now_tick      (req_now_tick),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_way           (rsp_way),
      .rsp_filled        (rsp_filled),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_invalidated   (rsp_invalidated)
   );

endmodule : sector_cache_lru_tags

`default_nettype wire

@@ bench/sector_cache_lru_tags_tb.sv @@
// testbench for the sector cache tag and replacement controller (sector_cache_lru_tags)
// depends on slt_pkg and the sector_cache_lru_tags rtl; a built-in tag predictor
// checks every result, and the stimulus runs under several sender idle patterns
module sector_cache_lru_tags_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import slt_pkg::*;

   // one expected result per request
   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] way;
      logic             filled;
      logic             evicted_valid;
      logic             invalidated;
   } lookup_result_type;

   localparam int WATCHDOG_LIMIT   = 1000;
   localparam int DRAIN_CYCLES     = 4;
   localparam int RANDOM_PER_PHASE = 580;
   localparam int POOL_SIZE        = 12;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_opcode = OP_READ;
   logic [SECTOR_W-1:0] req_sector = '0;
   logic [STAMP_W-1:0]  req_now_tick = '0;
   logic                rsp_valid;
   logic                rsp_hit;
   logic [WAY_W-1:0]    rsp_way;
   logic                rsp_filled;
   logic                rsp_evicted_valid;
   logic                rsp_invalidated;

   // predictor copy of the tag store
   logic                tags_valid  [CACHE_WAYS] = '{default: 1'b0};
   logic [SECTOR_W-1:0] tags_sector [CACHE_WAYS] = '{default: '0};
   logic [STAMP_W-1:0]  tags_stamp  [CACHE_WAYS] = '{default: '0};

   lookup_result_type pending_lookups[$];
   int             failures = 0;
   int             idle_cycles = 0;

   always #1 clock = ~clock;

   sector_cache_lru_tags uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_sector        (req_sector),
      .req_now_tick      (req_now_tick),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_way           (rsp_way),
      .rsp_filled        (rsp_filled),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_invalidated   (rsp_invalidated)
   );

   // lookup, fill or invalidate against the predictor tag store
   function automatic lookup_result_type cache_lookup(input logic                op,
                                                      input logic [SECTOR_W-1:0] sec,
                                                      input logic [STAMP_W-1:0]  tick);
      lookup_result_type   res;
      int                  victim;
      logic [STAMP_W-1:0]  oldest;
      res = '0;
      if (int'(sec) >= NUM_SECTORS) return res;
      // write clears every way holding the sector
      if (op == OP_WRITE) begin
         for (int i = 0; i < CACHE_WAYS; i++) begin
            if (tags_sector[i] == sec) begin
               if (tags_valid[i]) res.invalidated = 1'b1;
               tags_valid[i] = 1'b0;
            end
         end
         return res;
      end
      // read hit refreshes the stamp of the first matching way
      for (int i = 0; i < CACHE_WAYS; i++) begin
         if (tags_valid[i] && tags_sector[i] == sec) begin
            tags_stamp[i] = tick;
            res.hit = 1'b1;
            res.way = WAY_W'(i);
            return res;
         end
      end
      // miss: first free way, else oldest stamp with lowest index on a tie
      victim = -1;
      for (int i = 0; i < CACHE_WAYS; i++) begin
         if (!tags_valid[i] && victim < 0) victim = i;
      end
      if (victim < 0) begin
         victim = 0;
         oldest = tags_stamp[0];
         for (int i = 1; i < CACHE_WAYS; i++) begin
            if (tags_stamp[i] < oldest) begin
               oldest = tags_stamp[i];
               victim = i;
            end
         end
         res.evicted_valid = 1'b1;
      end
      tags_valid[victim]  = 1'b1;
      tags_sector[victim] = sec;
      tags_stamp[victim]  = tick;
      res.filled = 1'b1;
      res.way    = WAY_W'(victim);
      return res;
   endfunction

   // present one request and hold it until the block takes it
   task automatic send_request(input logic                op,
                               input logic [SECTOR_W-1:0] sec,
                               input logic [STAMP_W-1:0]  tick);
      @(negedge clock);
      start        <= 1'b1;
      req_opcode   <= op;
      req_sector   <= sec;
      req_now_tick <= tick;
      do @(posedge clock); while (busy);
      pending_lookups.push_back(cache_lookup(op, sec, tick));
   endtask

   // sender gap with junk on the request fields
   task automatic maybe_idle(input int idle_pct);
      if ($urandom_range(99, 0) < idle_pct) begin
         @(negedge clock);
         start        <= 1'b0;
         req_opcode   <= 1'($urandom);
         req_sector   <= SECTOR_W'($urandom);
         req_now_tick <= $urandom;
         repeat ($urandom_range(3, 0)) @(negedge clock);
      end
   endtask

   task automatic wait_for_results();
      while (pending_lookups.size() != 0) @(posedge clock);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      start <= 1'b0;
   endtask

   // field extremes, hits, fills, invalidation, eviction and stamp ties
   task automatic test_directed();
      send_request(OP_READ,  10'd0,    32'd0);
      send_request(OP_READ,  10'd1023, 32'hFFFF_FFFF);
      send_request(OP_READ,  10'd0,    32'd5);
      send_request(OP_WRITE, 10'd1023, 32'd0);
      send_request(OP_WRITE, 10'd1023, 32'hFFFF_FFFF);
      send_request(OP_READ,  10'd512,  32'd7);
      for (int s = 2; s < 8; s++) send_request(OP_READ, SECTOR_W'(s), STAMP_W'(18 + s));
      send_request(OP_READ,  10'd100,  32'd10);
      send_request(OP_READ,  10'd512,  32'd3);
      send_request(OP_READ,  10'd2,    32'd3);
      send_request(OP_READ,  10'd200,  32'd9);
      send_request(OP_READ,  10'd4,    32'hFFFF_FFFF);
      send_request(OP_READ,  10'd3,    32'd0);
      send_request(OP_READ,  10'd341,  32'h8000_0000);
      send_request(OP_WRITE, 10'd999,  32'd1);
      send_request(OP_WRITE, 10'd682,  32'h5555_5555);
      send_request(OP_READ,  10'd1023, 32'hAAAA_AAAA);
      send_request(OP_READ,  10'd0,    32'h0000_0001);
      stop_sending();
      wait_for_results();
   endtask

   // mostly a small hot set of sectors so hits, refills and evictions dominate
   task automatic test_random_traffic(input int idle_pct);
      logic [SECTOR_W-1:0] pool [POOL_SIZE];
      logic [STAMP_W-1:0]  tick_now;
      logic                op;
      logic [SECTOR_W-1:0] sec;
      logic [STAMP_W-1:0]  tick;
      int                  sel;
      foreach (pool[k]) pool[k] = SECTOR_W'($urandom_range(NUM_SECTORS - 1, 0));
      tick_now = $urandom;
      repeat (RANDOM_PER_PHASE) begin
         op  = ($urandom_range(99, 0) < 20) ? OP_WRITE : OP_READ;
         sec = ($urandom_range(99, 0) < 85) ? pool[$urandom_range(POOL_SIZE - 1, 0)]
                                            : SECTOR_W'($urandom_range(NUM_SECTORS - 1, 0));
         sel = $urandom_range(99, 0);
         if (sel < 8)
            tick = $urandom;
         else if (sel < 11)
            tick = '1;
         else if (sel < 14)
            tick = '0;
         else begin
            // small steps give stamp ties and occasional wrap
            tick_now += STAMP_W'($urandom_range(3, 0));
            tick = tick_now;
         end
         maybe_idle(idle_pct);
         send_request(op, sec, tick);
      end
      stop_sending();
      wait_for_results();
   endtask

   // result checker against the oldest pending lookup
   always @(posedge clock) begin
      lookup_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_lookups.size() == 0) begin
            $error("result with no request pending");
            failures++;
         end else begin
            exp_r = pending_lookups.pop_front();
            if (rsp_hit !== exp_r.hit) begin
               $error("hit: expected %0d, actual %0d", exp_r.hit, rsp_hit);
               failures++;
            end
            if (rsp_way !== exp_r.way) begin
               $error("way: expected %0d, actual %0d", exp_r.way, rsp_way);
               failures++;
            end
            if (rsp_filled !== exp_r.filled) begin
               $error("filled: expected %0d, actual %0d", exp_r.filled, rsp_filled);
               failures++;
            end
            if (rsp_evicted_valid !== exp_r.evicted_valid) begin
               $error("evicted_valid: expected %0d, actual %0d",
                      exp_r.evicted_valid, rsp_evicted_valid);
               failures++;
            end
            if (rsp_invalidated !== exp_r.invalidated) begin
               $error("invalidated: expected %0d, actual %0d",
                      exp_r.invalidated, rsp_invalidated);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles with no request taken and no result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL sector_cache_lru_tags");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // test sequence
   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic(0);
      test_random_traffic(71);
      test_random_traffic(37);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending_lookups.size() == 0)
         $display("PASS sector_cache_lru_tags");
      else
         $display("FAIL sector_cache_lru_tags");
      $finish;
   end

endmodule

@@ filelist.f @@
src/slt_pkg.sv
src/slt_ctrl.sv
src/slt_dp.sv
src/sector_cache_lru_tags.sv
bench/sector_cache_lru_tags_tb.sv
